// File: rtl/epr_pkg.sv
// Shared types and constants for the echo pulse ranger.
package epr_pkg;

	localparam int SCALE_W = 8;
	localparam int DIST_W = 20;
	localparam int CM_W = 10;
	localparam int CFG_INDEX_W = 2;
	localparam int RING_DEPTH = 3;

	localparam logic [CM_W-1:0] CM_MAX = 10'd1023;

	localparam int RECIP_W = 21;
	localparam int RECIP_SHIFT = 30;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 21'd1073742;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd17;
	localparam logic [DIST_W-1:0] MIN_RESET = 20'd2000;
	localparam logic [DIST_W-1:0] MAX_RESET = 20'd400000;

	localparam logic [CFG_INDEX_W-1:0] REG_SCALE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX = 2'd2;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_REVERSED = 2'd2;

	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic [DIST_W-1:0] min_dist;
		logic [DIST_W-1:0] max_dist;
	} cfg_t;

	typedef struct packed {
		logic store;
		logic reject;
		logic [CM_W-1:0] cm;
	} res_t;

endpackage

// File: rtl/echo_pulse_range_median3.sv
// Top level of the echo pulse ranger with a three-sample median.
//
// Usage: each input transfer on in_valid/in_stall carries one captured echo
// edge count. Edges pair up as start then end; an end count not above the
// start count is rejected and the next edge is again taken as an end edge.
// Every input transfer yields exactly one output transfer on
// out_valid/out_stall with the median of the three stored distances in cm
// and the stored/rejected flags.
// One edge per cycle is taken as long as the output is drained, through the
// four-stage pipeline of edge pairing, scale multiply, reciprocal divide and
// ring update.
// The ring is a chain of three cells that shift on every stored sample.
// Reset clears the ring to zero, sets the scale to 17 and the limits to
// 2000 and 400000 thousandths of a cm, and expects a start edge next.
// When out_stall holds, results wait in the output register and the
// pipeline stages fill; in_stall rises once no stage is free.
// Write cfg_data to register cfg_index with cfg_wr_en only while idle.
module echo_pulse_range_median3 #(
	parameter int COUNT_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [epr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [epr_pkg::DIST_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [31:0] capture_count,
	output logic out_valid,
	input  logic out_stall,
	output logic [epr_pkg::CM_W-1:0] median_distance_cm,
	output logic sample_stored,
	output logic pulse_rejected
);

	epr_pkg::cfg_t cfg_q;
	logic advance;
	logic res_valid;
	epr_pkg::res_t res;
	logic fire;
	logic shift;
	logic [epr_pkg::CM_W-1:0] ring [epr_pkg::RING_DEPTH];
	logic [epr_pkg::CM_W-1:0] median_d;
	logic out_valid_q;
	logic [epr_pkg::CM_W-1:0] median_q;
	logic stored_q;
	logic rejected_q;

	function automatic logic [epr_pkg::CM_W-1:0] mid3(
		input logic [epr_pkg::CM_W-1:0] a,
		input logic [epr_pkg::CM_W-1:0] b,
		input logic [epr_pkg::CM_W-1:0] c
	);
		logic [epr_pkg::CM_W-1:0] lo, hi, hc;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		hc = (hi < c) ? hi : c;
		return (lo > hc) ? lo : hc;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale <= epr_pkg::SCALE_RESET;
			cfg_q.min_dist <= epr_pkg::MIN_RESET;
			cfg_q.max_dist <= epr_pkg::MAX_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				epr_pkg::REG_SCALE: cfg_q.scale <= cfg_data[epr_pkg::SCALE_W-1:0];
				epr_pkg::REG_MIN: cfg_q.min_dist <= cfg_data;
				epr_pkg::REG_MAX: cfg_q.max_dist <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance = !out_valid_q || !out_stall;
	assign fire = res_valid && advance;
	assign shift = fire && res.store;

	epr_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.capture_count(capture_count),
		.cfg(cfg_q),
		.advance(advance),
		.res_valid(res_valid),
		.res(res)
	);

	for (genvar i = 0; i < epr_pkg::RING_DEPTH; i++) begin : g_ring
		if (i == 0) begin : g_head
			epr_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.shift(shift),
				.d(res.cm),
				.q(ring[i])
			);
		end else begin : g_tail
			epr_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.shift(shift),
				.d(ring[i-1]),
				.q(ring[i])
			);
		end
	end

	assign median_d = res.store ? mid3(res.cm, ring[0], ring[1])
		: mid3(ring[0], ring[1], ring[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			median_q <= median_d;
			stored_q <= res.store;
			rejected_q <= res.reject;
		end
	end

	assign out_valid = out_valid_q;
	assign median_distance_cm = median_q;
	assign sample_stored = stored_q;
	assign pulse_rejected = rejected_q;

endmodule

// File: rtl/epr_cell.sv
// One entry of the distance ring, shifting to its neighbor on a store.
module epr_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  logic [epr_pkg::CM_W-1:0] d,
	output logic [epr_pkg::CM_W-1:0] q
);

	logic [epr_pkg::CM_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (shift) begin
			value_q <= d;
		end
	end

	assign q = value_q;

endmodule

// File: rtl/epr_front.sv
// Edge pairing, width scaling, range check and conversion to whole cm.
module epr_front #(
	parameter int COUNT_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [31:0] capture_count,
	input  epr_pkg::cfg_t cfg,
	input  logic advance,
	output logic res_valid,
	output epr_pkg::res_t res
);

	localparam int DW = COUNT_BITS + epr_pkg::SCALE_W;
	localparam int PW = epr_pkg::DIST_W + epr_pkg::RECIP_W;

	logic expect_q;
	logic [COUNT_BITS-1:0] start_q;

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	logic [1:0] kind_s1, kind_s2;
	logic [COUNT_BITS-1:0] width_s1;
	logic in_range_s2;
	logic [epr_pkg::DIST_W-1:0] dist_s2;
	epr_pkg::res_t res_s3;

	logic [COUNT_BITS-1:0] cnt;
	logic accept;
	logic [1:0] kind_d;
	logic [DW-1:0] dist_full;
	logic in_range;
	logic [PW-1:0] prod;
	logic [epr_pkg::CM_W:0] cm_raw;
	logic [epr_pkg::CM_W-1:0] cm_sat;

	assign en3 = !v_s3 || advance;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;
	assign accept = in_valid && en1;
	assign cnt = capture_count[COUNT_BITS-1:0];

	always_comb begin
		if (expect_q) begin
			kind_d = epr_pkg::KIND_START;
		end else if (cnt <= start_q) begin
			kind_d = epr_pkg::KIND_REVERSED;
		end else begin
			kind_d = epr_pkg::KIND_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= 1'b1;
			start_q <= '0;
		end else if (accept) begin
			if (expect_q) begin
				start_q <= cnt;
				expect_q <= 1'b0;
			end else if (kind_d == epr_pkg::KIND_END) begin
				expect_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	assign dist_full = {{epr_pkg::SCALE_W{1'b0}}, width_s1}
		* {{COUNT_BITS{1'b0}}, cfg.scale};
	assign in_range = (dist_full >= {{(DW-epr_pkg::DIST_W){1'b0}}, cfg.min_dist})
		&& (dist_full <= {{(DW-epr_pkg::DIST_W){1'b0}}, cfg.max_dist});

	assign prod = {{epr_pkg::RECIP_W{1'b0}}, dist_s2}
		* {{epr_pkg::DIST_W{1'b0}}, epr_pkg::RECIP_1000};
	assign cm_raw = prod[PW-1:epr_pkg::RECIP_SHIFT];
	assign cm_sat = cm_raw[epr_pkg::CM_W] ? epr_pkg::CM_MAX : cm_raw[epr_pkg::CM_W-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_d;
			width_s1 <= cnt - start_q;
		end
		if (en2 && v_s1) begin
			kind_s2 <= kind_s1;
			in_range_s2 <= in_range;
			dist_s2 <= dist_full[epr_pkg::DIST_W-1:0];
		end
		if (en3 && v_s2) begin
			res_s3.store <= (kind_s2 == epr_pkg::KIND_END) && in_range_s2;
			res_s3.reject <= (kind_s2 == epr_pkg::KIND_REVERSED)
				|| ((kind_s2 == epr_pkg::KIND_END) && !in_range_s2);
			res_s3.cm <= cm_sat;
		end
	end

	assign res_valid = v_s3;
	assign res = res_s3;

endmodule
